>>> src/wvo_pkg.sv
// ----------------------------------------------------------------------------
// wvo_pkg
// Shared constants for the wavetable oscillator: register indexes, wave codes,
// configuration port widths and the fixed-point angle constant for the sine ROM.
// ----------------------------------------------------------------------------
package wvo_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HZ_SCALE    = 1'b1;

    // Wave select codes
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SAW      = 2'd1;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [1:0] WAVE_SQUARE   = 2'd3;

    // Register reset values
    localparam logic [1:0]  WAVE_SELECT_RST = WAVE_SINE;
    localparam logic [19:0] HZ_SCALE_RST    = 20'd97392;   // 2^32 / 44100

    // Input field widths
    localparam int FREQ_W  = 24;
    localparam int PHASE_W = 32;
    localparam int FRAC_W  = 16;

    // 2*pi in Q30
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

endpackage

>>> src/wvo_sine_rom.sv
// ----------------------------------------------------------------------------
// wvo_sine_rom
// Sine table built at elaboration (Q30 Taylor series with quarter-wave
// folding), read at two addresses per cycle while enabled; registered outputs.
// ----------------------------------------------------------------------------
module wvo_sine_rom
    import wvo_pkg::*;
#(
    parameter int TABLE_SIZE   = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [$clog2(TABLE_SIZE)-1:0]        i_addr_a,
    input  logic [$clog2(TABLE_SIZE)-1:0]        i_addr_b,
    output logic signed [SAMPLE_WIDTH-1:0]       o_data_a,
    output logic signed [SAMPLE_WIDTH-1:0]       o_data_b
);

    localparam int HALF    = TABLE_SIZE / 2;
    localparam int QUARTER = TABLE_SIZE / 4;
    localparam int SHR     = 31 - SAMPLE_WIDTH;

    // One ROM entry: round(ONE * sin(2*pi*i/N)), top value saturated
    function automatic logic signed [SAMPLE_WIDTH-1:0] sine_entry(input int unsigned i);
        logic [63:0]        t;
        logic [63:0]        theta;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        s;
        logic signed [63:0] acc;
        logic signed [63:0] v;
        t = 64'(i) % 64'(HALF);
        if (t > 64'(QUARTER)) begin
            t = 64'(HALF) - t;
        end
        theta = (t * TWO_PI_Q30 + 64'(HALF)) / 64'(TABLE_SIZE);
        t2    = (theta * theta) >> 30;
        term  = theta;
        acc   = $signed(theta);
        term  = ((term * t2) >> 30) / 64'd6;
        acc   = acc - $signed(term);
        term  = ((term * t2) >> 30) / 64'd20;
        acc   = acc + $signed(term);
        term  = ((term * t2) >> 30) / 64'd42;
        acc   = acc - $signed(term);
        term  = ((term * t2) >> 30) / 64'd72;
        acc   = acc + $signed(term);
        term  = ((term * t2) >> 30) / 64'd110;
        acc   = acc - $signed(term);
        term  = ((term * t2) >> 30) / 64'd156;
        acc   = acc + $signed(term);
        term  = ((term * t2) >> 30) / 64'd210;
        acc   = acc - $signed(term);
        if (acc < 0) begin
            acc = 64'sd0;
        end
        s = ($unsigned(acc) + (64'd1 << (SHR - 1))) >> SHR;
        v = $signed(s);
        if (64'(i) >= 64'(HALF)) begin
            v = -v;
        end
        // positive full scale does not fit
        if (v > $signed((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1)) begin
            v = $signed((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
        end
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    logic signed [SAMPLE_WIDTH-1:0] rom_data [TABLE_SIZE];

    // Constant contents
    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
        assign rom_data[g] = sine_entry(g);
    end

    // Registered dual read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data_a <= rom_data[i_addr_a];
            o_data_b <= rom_data[i_addr_b];
        end
    end

endmodule

>>> src/wvo_wave_gen.sv
// ----------------------------------------------------------------------------
// wvo_wave_gen
// Table lookup stage: fetches the two neighboring entries of the selected
// waveform. Sine comes from the ROM, saw/triangle/square from the index.
// ----------------------------------------------------------------------------
module wvo_wave_gen
    import wvo_pkg::*;
#(
    parameter int TABLE_SIZE   = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [1:0]                           i_wave_sel,
    input  logic [$clog2(TABLE_SIZE)-1:0]        i_idx_a,
    input  logic [$clog2(TABLE_SIZE)-1:0]        i_idx_b,
    output logic signed [SAMPLE_WIDTH-1:0]       o_entry_a,
    output logic signed [SAMPLE_WIDTH-1:0]       o_entry_b
);

    localparam int IB = $clog2(TABLE_SIZE);
    localparam int SW = SAMPLE_WIDTH;

    localparam logic [SW-1:0] POS_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] NEG_MIN = {1'b1, {(SW-1){1'b0}}};

    // Entry of a computed waveform for index i
    function automatic logic [SW-1:0] calc_entry(input logic [1:0] sel,
                                                 input logic [IB-1:0] i);
        logic [IB+SW-1:0] saw_w;
        logic [IB+SW-2:0] tri_w;
        logic [SW-1:0]    ramp;
        logic [SW-1:0]    t;
        logic [SW-1:0]    res;
        saw_w = {i, {SW{1'b0}}} >> IB;
        ramp  = saw_w[SW-1:0];
        tri_w = {i[IB-2:0], {SW{1'b0}}} >> (IB - 1);
        t     = tri_w[SW-1:0];
        case (sel)
            WAVE_SAW: begin
                res = {~ramp[SW-1], ramp[SW-2:0]};
            end
            WAVE_TRIANGLE: begin
                if (!i[IB-1]) begin
                    res = {~t[SW-1], t[SW-2:0]};
                end else if (t == '0) begin
                    res = POS_MAX;          // peak saturates
                end else begin
                    res = NEG_MIN - t;      // ONE - t, modulo 2^SW
                end
            end
            WAVE_SQUARE: begin
                res = i[IB-1] ? NEG_MIN : POS_MAX;
            end
            default: begin
                res = '0;                   // sine comes from the ROM
            end
        endcase
        return res;
    endfunction

    logic signed [SW-1:0] rom_a;
    logic signed [SW-1:0] rom_b;
    logic        [SW-1:0] r_calc_a;
    logic        [SW-1:0] r_calc_b;

    wvo_sine_rom #(
        .TABLE_SIZE   (TABLE_SIZE),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_sine_rom (
        .i_clk    (i_clk),
        .i_en     (i_en),
        .i_addr_a (i_idx_a),
        .i_addr_b (i_idx_b),
        .o_data_a (rom_a),
        .o_data_b (rom_b)
    );

    // Computed waves, registered alongside the ROM read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_calc_a <= calc_entry(i_wave_sel, i_idx_a);
            r_calc_b <= calc_entry(i_wave_sel, i_idx_b);
        end
    end

    // user must change wave_sel only while idle (not enforced) to keep it stable
    assign o_entry_a = (i_wave_sel == WAVE_SINE) ? rom_a : $signed(r_calc_a);
    assign o_entry_b = (i_wave_sel == WAVE_SINE) ? rom_b : $signed(r_calc_b);

endmodule

>>> src/wvo_interp.sv
// ----------------------------------------------------------------------------
// wvo_interp
// Linear interpolation between two table entries with a 16-bit fraction,
// floor rounding, into the result register.
// ----------------------------------------------------------------------------
module wvo_interp
    import wvo_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [SAMPLE_WIDTH-1:0] i_entry_a,
    input  logic signed [SAMPLE_WIDTH-1:0] i_entry_b,
    input  logic        [FRAC_W-1:0]       i_frac,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample
);

    localparam int SW = SAMPLE_WIDTH;

    logic signed [SW:0]          diff;
    logic signed [SW+FRAC_W+1:0] prod;
    logic        [SW-1:0]        n_sample;

    // a + floor(frac * (b - a) / 2^16); the result lies between a and b
    always_comb begin
        diff     = $signed({i_entry_b[SW-1], i_entry_b}) - $signed({i_entry_a[SW-1], i_entry_a});
        prod     = $signed({1'b0, i_frac}) * diff;
        n_sample = $unsigned(i_entry_a) + prod[SW+FRAC_W-1:FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sample <= $signed(n_sample);
        end
    end

endmodule

>>> src/wavetable_oscillator.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator
// Phase-accumulator wavetable oscillator with linear interpolation between
// adjacent table entries; sine, saw, triangle or square output.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tdata[23:0] frequency, tdata[55:24] phase_offset
//  m_axis   | out       | tdata[SAMPLE_WIDTH-1:0] sample, zero padded
//  cfg      | in        | idx 0 wave_select, idx 1 hz_scale (write only)
//
//  Three register stages: input register (phase add, accumulator update),
//  table lookup (registered ROM read), interpolation into the result register.
//  One sample per cycle sustained while m_axis_tready is high; an input passes the
//  input register, table lookup and result register before its sample is valid.
//  Each stage moves when it is empty or the next one moves, so input is taken
//  while a result waits if an earlier stage is empty. Synchronous active-low reset
//  clears the valid bits, phase accumulator and config registers; no clearing pass.
// ----------------------------------------------------------------------------
module wavetable_oscillator
    import wvo_pkg::*;
#(
    parameter int TABLE_SIZE   = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration
    input  logic                                    i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]                    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]                   i_cfg_wdata,
    // input stream
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [55:0]                             s_axis_tdata,  // frequency, phase_offset
    // output stream
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_axis_tdata   // sample
);

    localparam int IB    = $clog2(TABLE_SIZE);
    localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // configuration registers
    logic [1:0]            r_wave_sel;
    logic [19:0]           r_hz_scale;

    // stage valids and payload
    logic                  r_a_vld;
    logic                  r_b_vld;
    logic                  r_c_vld;
    logic signed [FREQ_W-1:0] r_a_freq;
    logic [PHASE_W-1:0]    r_a_off;
    logic [FRAC_W-1:0]     r_b_frac;
    logic [PHASE_W-1:0]    r_acc;

    logic                  en_a;
    logic                  en_b;
    logic                  en_c;
    logic [PHASE_W-1:0]    phase;
    logic signed [FREQ_W+20:0] inc_prod;
    logic [IB-1:0]         idx_a;
    logic [IB-1:0]         idx_b;
    logic signed [SAMPLE_WIDTH-1:0] entry_a;
    logic signed [SAMPLE_WIDTH-1:0] entry_b;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    // stage enables
    assign en_c          = !r_c_vld || m_axis_tready;
    assign en_b          = !r_b_vld || en_c;
    assign en_a          = !r_a_vld || en_b;
    assign s_axis_tready = en_a;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_sel <= WAVE_SELECT_RST;
            r_hz_scale <= HZ_SCALE_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_WAVE_SELECT: r_wave_sel <= i_cfg_wdata[1:0];
                CFG_HZ_SCALE:    r_hz_scale <= i_cfg_wdata;
                default:         ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (en_a) r_a_vld <= s_axis_tvalid;
            if (en_b) r_b_vld <= r_a_vld;
            if (en_c) r_c_vld <= r_b_vld;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_freq <= $signed(s_axis_tdata[FREQ_W-1:0]);
            r_a_off  <= s_axis_tdata[FREQ_W+PHASE_W-1:FREQ_W];
        end
    end

    // table position and phase increment
    always_comb begin
        phase    = r_acc + r_a_off;
        idx_a    = phase[PHASE_W-1 -: IB];
        idx_b    = idx_a + IB'(1);
        inc_prod = r_a_freq * $signed({1'b0, r_hz_scale});
    end

    // accumulator advances by floor(freq * hz_scale / 256), modulo 2^32
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_a_vld && en_b) begin
            r_acc <= r_acc + inc_prod[PHASE_W+7:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_frac <= phase[PHASE_W-1-IB -: FRAC_W];
        end
    end

    wvo_wave_gen #(
        .TABLE_SIZE   (TABLE_SIZE),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_wave_gen (
        .i_clk      (i_clk),
        .i_en       (en_b),
        .i_wave_sel (r_wave_sel),
        .i_idx_a    (idx_a),
        .i_idx_b    (idx_b),
        .o_entry_a  (entry_a),
        .o_entry_b  (entry_b)
    );

    wvo_interp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_interp (
        .i_clk     (i_clk),
        .i_en      (en_c),
        .i_entry_a (entry_a),
        .i_entry_b (entry_b),
        .i_frac    (r_b_frac),
        .o_sample  (sample)
    );

    assign m_axis_tvalid = r_c_vld;
    assign m_axis_tdata  = OUT_W'($unsigned(sample));

endmodule
